// ===== design/ttof_pkg.sv =====
package ttof_pkg;

	localparam int TOP_W     = 29;
	localparam int BOT_W     = 30;
	localparam int SUM_W     = 31;
	localparam int REM_W     = 32;
	localparam int K_W       = 24;
	localparam int ACC_W     = 44;
	localparam int P_W       = 68;
	localparam int D_W       = 45;
	localparam int DIV_STEPS = 23;
	localparam int POLY_N    = 6;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t POLY [0:POLY_N] = '{
		44'sd6750213153,
		-44'sd21732703812,
		44'sd29195703774,
		-44'sd20932801105,
		44'sd8441853689,
		-44'sd1812008388,
		44'sd161292928
	};

	localparam logic [8:0]  BOOST_PIXEL = 9'd176;
	localparam logic [28:0] RECIP25     = 29'd343597384;
	localparam int          RECIP_SHIFT = 33;
	localparam logic signed [D_W-1:0] OFFSET_Q12 = 45'sd13926;
	localparam logic signed [36:0]    THR_BASE   = 37'sd86835200;
	localparam logic [18:0]           AMB_THR    = 19'd409600;

	localparam logic [15:0] AMB_RST   = 16'd0;
	localparam logic [11:0] SENS_RST  = 12'd1065;
	localparam logic [11:0] THRES_RST = 12'd2200;
	localparam logic [15:0] LIMIT_RST = 16'd2500;

	typedef enum logic [1:0] {
		REG_AMBIENT,
		REG_SENS,
		REG_THRESH,
		REG_LIMIT
	} cfg_reg_t;

	typedef struct packed {
		logic       vld;
		logic [8:0] pix;
		logic       upd;
		logic       inr;
		logic       zero;
	} tag_t;

endpackage

// ===== design/two_tap_tof_pixel_distance.sv =====
// Two-tap pulsed time-of-flight distance, one pixel per item. Each item gives
// the reset and signal levels of both taps; the result carries the pixel's
// stored distance (meters times 100) and whether this item replaced it. The
// datapath is a 44-stage pipeline (ratio divider at one quotient bit per stage,
// Horner polynomial at two stages per term) and takes one item every cycle
// unless a held result stalls it or the store is being cleared. The per-pixel
// store is a RAM that is read and written in the result stage, so back-to-back
// items on the same pixel see each other's updates. After reset the store is
// cleared one entry per cycle while in_ready stays low; configuration writes are
// taken at any time but must only change while the pipeline is empty.
module two_tap_tof_pixel_distance #(
	parameter int PIXELS = 272
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [8:0]  pixel_index,
	input  logic [11:0] reset_a,
	input  logic [11:0] signal_a,
	input  logic [11:0] reset_b,
	input  logic [11:0] signal_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  out_pixel,
	output logic [15:0] distance,
	output logic        updated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int NDIV  = ttof_pkg::DIV_STEPS;
	localparam int NPOLY = ttof_pkg::POLY_N;

	logic [15:0] amb_q;
	logic [11:0] sens_q;
	logic [11:0] thres_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q   <= ttof_pkg::AMB_RST;
			sens_q  <= ttof_pkg::SENS_RST;
			thres_q <= ttof_pkg::THRES_RST;
			limit_q <= ttof_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (ttof_pkg::cfg_reg_t'(cfg_index))
				ttof_pkg::REG_AMBIENT: amb_q   <= cfg_data;
				ttof_pkg::REG_SENS:    sens_q  <= cfg_data[11:0];
				ttof_pkg::REG_THRESH:  thres_q <= cfg_data[11:0];
				ttof_pkg::REG_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(PIXELS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	logic out_valid_q;
	logic adv;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !clr_q;

	// stage 1: tap discharges
	logic signed [12:0] db_c, da_c;
	logic signed [25:0] dasr_c;
	logic [25:0]        amb_c;
	logic signed [ttof_pkg::TOP_W-1:0] top_c;
	logic signed [ttof_pkg::BOT_W-1:0] bot_c;
	ttof_pkg::tag_t tag_c;

	always_comb begin
		amb_c  = {amb_q, 10'b0};
		db_c   = $signed({1'b0, reset_b}) - $signed({1'b0, signal_b});
		da_c   = $signed({1'b0, reset_a}) - $signed({1'b0, signal_a});
		dasr_c = da_c * $signed({1'b0, sens_q});
		top_c  = $signed({{2{db_c[12]}}, db_c, 14'b0}) - $signed({3'b0, amb_c});
		bot_c  = $signed({dasr_c, 4'b0}) - $signed({4'b0, amb_c});
		tag_c.vld  = in_valid && in_ready;
		tag_c.pix  = pixel_index;
		tag_c.upd  = (signal_a > thres_q) && (signal_b > thres_q);
		tag_c.inr  = 32'(pixel_index) < PIXELS;
		tag_c.zero = 1'b0;
	end

	ttof_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [ttof_pkg::TOP_W-1:0] top_s1, top_s2, top_s3, top_s4;
	logic signed [ttof_pkg::BOT_W-1:0] bot_s1, bot_s2, bot_s3;
	logic [56:0]                       prod25_s2;
	logic signed [ttof_pkg::SUM_W-1:0] sum_s4;

	logic [23:0]                       q25_c;
	logic signed [ttof_pkg::BOT_W-1:0] botb_c;
	logic                              zero_c;
	logic signed [ttof_pkg::SUM_W-1:0] sum_c;
	ttof_pkg::tag_t                    tag3_c;

	always_comb begin
		q25_c  = prod25_s2[56:ttof_pkg::RECIP_SHIFT];
		botb_c = (tag_s2.pix == ttof_pkg::BOOST_PIXEL && !bot_s2[ttof_pkg::BOT_W-1]) ?
			bot_s2 + $signed({6'b0, q25_c}) : bot_s2;
		sum_c  = ttof_pkg::SUM_W'(top_s3) + ttof_pkg::SUM_W'(bot_s3);
		zero_c = bot_s3[ttof_pkg::BOT_W-1] ||
			($unsigned(bot_s3) > ttof_pkg::BOT_W'({limit_q, 14'b0}));
		tag3_c      = tag_s3;
		tag3_c.zero = zero_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_c;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag3_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s1    <= top_c;
			bot_s1    <= bot_c;
			top_s2    <= top_s1;
			bot_s2    <= bot_s1;
			prod25_s2 <= 57'(bot_s1[27:0]) * 57'(ttof_pkg::RECIP25);
			top_s3    <= top_s2;
			bot_s3    <= botb_c;
			top_s4    <= top_s3;
			sum_s4    <= sum_c;
		end
	end

	// stage 5: weak-signal check and divider setup
	logic signed [36:0] prod53_c, thr_c;
	logic [28:0]        mag_c;
	ttof_pkg::tag_t     dtag0_c;

	always_comb begin
		prod53_c = 37'(sum_s4) * 37'sd53;
		thr_c    = ttof_pkg::THR_BASE +
			$signed({2'b0, 35'(amb_q) * 35'(ttof_pkg::AMB_THR)});
		mag_c    = top_s4[ttof_pkg::TOP_W-1] ? 29'(-top_s4) : 29'(top_s4);
		dtag0_c      = tag_s4;
		dtag0_c.zero = tag_s4.zero || (prod53_c <= thr_c);
	end

	ttof_pkg::tag_t                   dtag_s [0:NDIV];
	logic [ttof_pkg::REM_W-1:0]       rem_s  [0:NDIV];
	logic [ttof_pkg::SUM_W-1:0]       dsor_s [0:NDIV];
	logic [NDIV-1:0]                  quo_s  [0:NDIV];
	logic                             neg_s  [0:NDIV];
	logic                             ovf_s  [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtag_s[0] <= '0;
		end else if (adv) begin
			dtag_s[0] <= dtag0_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= ttof_pkg::REM_W'(mag_c);
			dsor_s[0] <= $unsigned(sum_s4);
			quo_s[0]  <= '0;
			neg_s[0]  <= top_s4[ttof_pkg::TOP_W-1];
			ovf_s[0]  <= ttof_pkg::REM_W'(mag_c) >= {sum_s4, 1'b0};
		end
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		logic                       ge;
		logic [ttof_pkg::REM_W-1:0] rsub;

		always_comb begin
			ge   = rem_s[j] >= {1'b0, dsor_s[j]};
			rsub = ge ? rem_s[j] - {1'b0, dsor_s[j]} : rem_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dtag_s[j+1] <= '0;
			end else if (adv) begin
				dtag_s[j+1] <= dtag_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1]  <= {rsub[ttof_pkg::REM_W-2:0], 1'b0};
				dsor_s[j+1] <= dsor_s[j];
				quo_s[j+1]  <= {quo_s[j][NDIV-2:0], ge};
				neg_s[j+1]  <= neg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
			end
		end
	end

	// clamp quotient into signed k
	logic signed [ttof_pkg::K_W-1:0] k_c;

	always_comb begin
		if (neg_s[NDIV]) begin
			k_c = ovf_s[NDIV] ? $signed({1'b1, {(ttof_pkg::K_W-1){1'b0}}}) :
				-$signed({1'b0, quo_s[NDIV]});
		end else begin
			k_c = ovf_s[NDIV] ? $signed({1'b0, {(ttof_pkg::K_W-1){1'b1}}}) :
				$signed({1'b0, quo_s[NDIV]});
		end
	end

	ttof_pkg::tag_t                  htag_s [0:NPOLY];
	ttof_pkg::acc_t                  hacc_s [0:NPOLY];
	logic signed [ttof_pkg::K_W-1:0] hk_s   [0:NPOLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			htag_s[0] <= '0;
		end else if (adv) begin
			htag_s[0] <= dtag_s[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hk_s[0] <= k_c;
		end
	end

	assign hacc_s[0] = ttof_pkg::POLY[0];

	for (genvar i = 1; i <= NPOLY; i++) begin : g_horner
		ttof_pkg::tag_t                  mtag_s;
		logic signed [ttof_pkg::K_W-1:0] mk_s;
		logic signed [51:0]              ph_s;
		logic signed [40:0]              pl_s;
		logic signed [ttof_pkg::P_W-1:0] p;
		logic signed [ttof_pkg::P_W-1:0] psh;
		logic                            rb;
		ttof_pkg::acc_t                  nacc;

		always_comb begin
			p    = $signed({ph_s, 16'b0}) + ttof_pkg::P_W'(pl_s);
			psh  = p >>> 22;
			rb   = p[ttof_pkg::P_W-1] && (p[21:0] != 22'd0);
			nacc = $signed(psh[ttof_pkg::ACC_W-1:0]) +
				$signed({{(ttof_pkg::ACC_W-1){1'b0}}, rb}) + ttof_pkg::POLY[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mtag_s    <= '0;
				htag_s[i] <= '0;
			end else if (adv) begin
				mtag_s    <= htag_s[i-1];
				htag_s[i] <= mtag_s;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ph_s      <= $signed(hacc_s[i-1][ttof_pkg::ACC_W-1:16]) * hk_s[i-1];
				pl_s      <= $signed({1'b0, hacc_s[i-1][15:0]}) * hk_s[i-1];
				mk_s      <= hk_s[i-1];
				hacc_s[i] <= nacc;
				hk_s[i]   <= mk_s;
			end
		end
	end

	// final offset, clamp and scale
	logic signed [27:0]              k10_c;
	logic signed [17:0]              t10_c;
	logic signed [ttof_pkg::D_W-1:0] d_c;

	always_comb begin
		k10_c = 28'(hk_s[NPOLY]) * 28'sd10;
		t10_c = $signed(k10_c[27:10]) +
			$signed({17'b0, k10_c[27] && (k10_c[9:0] != 10'd0)});
		d_c   = ttof_pkg::D_W'(hacc_s[NPOLY]) + ttof_pkg::OFFSET_Q12 -
			ttof_pkg::D_W'(t10_c);
	end

	ttof_pkg::tag_t                  ftag_s1, ftag_s2;
	logic signed [ttof_pkg::D_W-1:0] d_s1;
	logic [15:0]                     dist_s2;
	logic [50:0]                     m100_c;
	logic [15:0]                     dist_c;

	always_comb begin
		m100_c = 51'(d_s1[ttof_pkg::D_W-2:0]) * 51'd100;
		if (ftag_s1.zero || d_s1[ttof_pkg::D_W-1] || d_s1 == '0) begin
			dist_c = '0;
		end else if (m100_c[50:28] != '0) begin
			dist_c = 16'hFFFF;
		end else begin
			dist_c = m100_c[27:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftag_s1 <= '0;
			ftag_s2 <= '0;
		end else if (adv) begin
			ftag_s1 <= htag_s[NPOLY];
			ftag_s2 <= ftag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1    <= d_c;
			dist_s2 <= dist_c;
		end
	end

	// store read-modify-write and result register
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [15:0]   st_wdata;
	logic [AW-1:0] st_raddr;
	logic [15:0]   st_rdata;

	always_comb begin
		st_raddr = AW'(ftag_s2.pix);
		if (clr_q) begin
			st_we    = 1'b1;
			st_waddr = clr_cnt_q;
			st_wdata = '0;
		end else begin
			st_we    = adv && ftag_s2.vld && ftag_s2.inr && ftag_s2.upd;
			st_waddr = st_raddr;
			st_wdata = dist_s2;
		end
	end

	ttof_ram #(
		.WIDTH (16),
		.DEPTH (PIXELS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (adv),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	logic [8:0]  pix_q;
	logic [15:0] dist_q;
	logic        upd_q;
	logic        inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ftag_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q  <= ftag_s2.pix;
			dist_q <= dist_s2;
			upd_q  <= ftag_s2.upd && ftag_s2.inr;
			inr_q  <= ftag_s2.inr;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = pix_q;
	assign updated   = upd_q;
	assign distance  = !inr_q ? 16'd0 : (upd_q ? dist_q : st_rdata);

endmodule

// ===== design/ttof_ram.sv =====
module ttof_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 272
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== bench/two_tap_tof_pixel_distance_checker.sv =====
module two_tap_tof_pixel_distance_checker #(
	parameter int PIXELS = 272
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [8:0]  pixel_index,
	input  logic [11:0] reset_a,
	input  logic [11:0] signal_a,
	input  logic [11:0] reset_b,
	input  logic [11:0] signal_b,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [8:0]  out_pixel,
	input  logic [15:0] distance,
	input  logic        updated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [8:0]  pix;
		logic [15:0] dist_val;
		logic        upd;
	} pixel_result_t;

	pixel_result_t result_q[$];
	logic [15:0] store_mirror [0:PIXELS-1];
	logic [15:0] amb_reg;
	logic [11:0] sens_reg;
	logic [11:0] thr_reg;
	logic [15:0] lim_reg;

	function automatic logic [15:0] tof_distance(input logic [8:0] pix,
		input logic [11:0] ra, input logic [11:0] sa,
		input logic [11:0] rb, input logic [11:0] sb);
		longint amb, top, bot, sum, thr, k, acc, d;
		longint coef [0:6];
		coef[0] = 64'sd6750213153;
		coef[1] = -64'sd21732703812;
		coef[2] = 64'sd29195703774;
		coef[3] = -64'sd20932801105;
		coef[4] = 64'sd8441853689;
		coef[5] = -64'sd1812008388;
		coef[6] = 64'sd161292928;
		amb = longint'(amb_reg) * 1024;
		top = (longint'(rb) - longint'(sb)) * 16384 - amb;
		bot = (longint'(ra) - longint'(sa)) * longint'(sens_reg) * 16 - amb;
		if (pix == 9'd176)
			bot = bot * 26 / 25;
		if (bot < 0 || bot > longint'(lim_reg) * 16384)
			return 16'd0;
		sum = top + bot;
		thr = longint'(53) * 100 * 16384 + amb * 400;
		if (sum * 53 <= thr)
			return 16'd0;
		k = top * 4194304 / sum;
		if (k > 8388607)
			k = 8388607;
		if (k < -8388608)
			k = -8388608;
		acc = coef[0];
		for (int i = 1; i < 7; i++)
			acc = acc * k / 4194304 + coef[i];
		d = acc + 13926 - (k * 10) / 1024;
		if (d <= 0)
			return 16'd0;
		d = d * 100 / 4096;
		if (d > 65535)
			d = 65535;
		return d[15:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t r, exp_r;
		logic [15:0] dv;
		if (!arst_n) begin
			result_q.delete();
			errors = 0;
			for (int i = 0; i < PIXELS; i++)
				store_mirror[i] = '0;
			amb_reg = ttof_pkg::AMB_RST;
			sens_reg = ttof_pkg::SENS_RST;
			thr_reg = ttof_pkg::THRES_RST;
			lim_reg = ttof_pkg::LIMIT_RST;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected item pixel", out_pixel, -1);
				end else begin
					exp_r = result_q.pop_front();
					if (out_pixel !== exp_r.pix)
						report_mismatch("out_pixel", out_pixel, exp_r.pix);
					if (distance !== exp_r.dist_val)
						report_mismatch("distance", distance, exp_r.dist_val);
					if (updated !== exp_r.upd)
						report_mismatch("updated", updated, exp_r.upd);
				end
			end
			if (in_valid && in_ready) begin
				r.pix = pixel_index;
				if (pixel_index >= PIXELS) begin
					r.dist_val = '0;
					r.upd = 1'b0;
				end else begin
					dv = tof_distance(pixel_index, reset_a, signal_a, reset_b, signal_b);
					r.upd = (signal_a > thr_reg) && (signal_b > thr_reg);
					if (r.upd)
						store_mirror[pixel_index] = dv;
					r.dist_val = store_mirror[pixel_index];
				end
				result_q.push_back(r);
			end
			if (cfg_we) begin
				case (ttof_pkg::cfg_reg_t'(cfg_index))
					ttof_pkg::REG_AMBIENT: amb_reg = cfg_data;
					ttof_pkg::REG_SENS:    sens_reg = cfg_data[11:0];
					ttof_pkg::REG_THRESH:  thr_reg = cfg_data[11:0];
					ttof_pkg::REG_LIMIT:   lim_reg = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== bench/two_tap_tof_pixel_distance_test.sv =====
module two_tap_tof_pixel_distance_test;

	localparam int PIXELS = 272;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [8:0]  pixel_index;
	logic [11:0] reset_a;
	logic [11:0] signal_a;
	logic [11:0] reset_b;
	logic [11:0] signal_b;
	logic        out_valid;
	logic        out_ready;
	logic [8:0]  out_pixel;
	logic [15:0] distance;
	logic        updated;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;
	int          hold_off;

	two_tap_tof_pixel_distance #(.PIXELS(PIXELS)) dut (.*);

	two_tap_tof_pixel_distance_checker #(.PIXELS(PIXELS)) checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver stall pattern, with a long hold-off when asked
	initial begin
		int mode;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off = hold_off - 1;
			end else begin
				mode = $urandom_range(0, 3);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send_item(input logic [8:0] pix, input logic [11:0] ra,
		input logic [11:0] sa, input logic [11:0] rb, input logic [11:0] sb);
		in_valid <= 1'b1;
		pixel_index <= pix;
		reset_a <= ra;
		signal_a <= sa;
		reset_b <= rb;
		signal_b <= sb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n)
			@(negedge clk);
	endtask

	task automatic drain_and_wait;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (60)
			@(negedge clk);
	endtask

	task automatic write_reg(input ttof_pkg::cfg_reg_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_pixel_item;
		logic [8:0] pix;
		logic [11:0] ra, sa, rb, sb;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			pix = 9'($urandom_range(PIXELS, 511));
		else if (sel < 4)
			pix = 9'd176;
		else if (sel < 8)
			pix = 9'($urandom_range(0, 7));
		else
			pix = 9'($urandom_range(0, PIXELS - 1));
		if ($urandom_range(0, 4) == 0) begin
			ra = 12'($urandom);
			sa = 12'($urandom);
			rb = 12'($urandom);
			sb = 12'($urandom);
		end else begin
			// plausible exposure: strong signals, modest discharges
			sa = 12'($urandom_range(1500, 4000));
			sb = 12'($urandom_range(1500, 4000));
			ra = 12'(sa + $urandom_range(0, 4095 - sa));
			rb = 12'(sb + $urandom_range(0, 4095 - sb));
			if ($urandom_range(0, 1))
				ra = 12'(sa + $urandom_range(0, (4095 - sa) > 2400 ? 2400 : (4095 - sa)));
		end
		send_item(pix, ra, sa, rb, sb);
	endtask

	task automatic random_phase(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && sent < count) begin
				random_pixel_item();
				burst--;
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(0, 8));
		end
	endtask

	initial begin
		in_valid = 1'b0;
		pixel_index = '0;
		reset_a = '0;
		signal_a = '0;
		reset_b = '0;
		signal_b = '0;
		cfg_we = 1'b0;
		cfg_index = ttof_pkg::REG_AMBIENT;
		cfg_data = '0;
		hold_off = 0;
		arst_n = 1'b0;
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes and special cases at reset settings
		send_item(9'd0, 12'd4095, 12'd2300, 12'd4095, 12'd2300);
		send_item(9'd0, 12'd3000, 12'd2300, 12'd3500, 12'd2300);
		send_item(9'd0, 12'd0, 12'd4095, 12'd0, 12'd4095);
		send_item(9'd0, 12'd4095, 12'd0, 12'd4095, 12'd0);
		send_item(9'd176, 12'd3500, 12'd2500, 12'd3300, 12'd2500);
		send_item(9'd175, 12'd3500, 12'd2500, 12'd3300, 12'd2500);
		send_item(9'd271, 12'd2600, 12'd2500, 12'd2600, 12'd2500);
		send_item(9'd272, 12'd4000, 12'd2500, 12'd3000, 12'd2500);
		send_item(9'd511, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_item(9'd5, 12'd2300, 12'd2300, 12'd4095, 12'd2300);
		send_item(9'd5, 12'd4095, 12'd2300, 12'd2300, 12'd2300);
		send_item(9'd5, 12'd3000, 12'd2200, 12'd3000, 12'd2201);
		send_item(9'd5, 12'd3000, 12'd2201, 12'd3000, 12'd2201);
		send_item(9'd5, 12'd2400, 12'd2201, 12'd2250, 12'd2201);
		send_item(9'd5, 12'd3000, 12'd2100, 12'd3000, 12'd2100);
		send_item(9'd6, 12'd4095, 12'd2300, 12'd2310, 12'd2300);
		send_item(9'd6, 12'd2310, 12'd2300, 12'd4095, 12'd2300);
		send_item(9'd256, 12'd3500, 12'd2500, 12'd3000, 12'd2500);
		drain_and_wait();

		write_reg(ttof_pkg::REG_AMBIENT, 16'hFFFF);
		write_reg(ttof_pkg::REG_SENS, 16'hFFFF);
		write_reg(ttof_pkg::REG_THRESH, 16'd0);
		write_reg(ttof_pkg::REG_LIMIT, 16'hFFFF);
		send_item(9'd1, 12'd4095, 12'd0, 12'd4095, 12'd1);
		send_item(9'd2, 12'd4095, 12'd1, 12'd4095, 12'd0);
		random_phase(120);
		drain_and_wait();

		write_reg(ttof_pkg::REG_AMBIENT, 16'd0);
		write_reg(ttof_pkg::REG_SENS, 16'd0);
		write_reg(ttof_pkg::REG_THRESH, 16'hFFF);
		write_reg(ttof_pkg::REG_LIMIT, 16'd0);
		random_phase(60);
		drain_and_wait();

		write_reg(ttof_pkg::REG_AMBIENT, 16'd800);
		write_reg(ttof_pkg::REG_SENS, 16'd1065);
		write_reg(ttof_pkg::REG_THRESH, 16'd1400);
		write_reg(ttof_pkg::REG_LIMIT, 16'd2500);
		// fill the pipeline against a stalled receiver
		hold_off = 400;
		random_phase(200);
		drain_and_wait();

		for (int phase = 0; phase < 4; phase++) begin
			write_reg(ttof_pkg::REG_AMBIENT, 16'($urandom_range(0, 4000)));
			write_reg(ttof_pkg::REG_SENS, 16'($urandom_range(700, 1400)));
			write_reg(ttof_pkg::REG_THRESH, 16'($urandom_range(1000, 2600)));
			write_reg(ttof_pkg::REG_LIMIT, 16'($urandom_range(500, 65535)));
			random_phase(90);
			drain_and_wait();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
